[design/cc20_pkg.sv]
// Package with shared types and constants of the ChaCha20 stream XOR block.
`timescale 1ns / 1ps
package cc20_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int QR_PER_DOUBLE = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY3 = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_FINAL,
        S_XOR,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take_item;   // latch input byte, maybe nonce
        logic       restart;     // start flag: clear counter and position
        logic       load;        // copy initial state into working words
        logic       qr_step;     // run one quarter round
        logic [2:0] qr_sel;      // which quarter round of the double round
        logic       finalize;    // add initial state back
        logic       make_out;    // form the output byte and advance position
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_block;        // position is zero
    } t_status;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

endpackage

[design/chacha20_stream_xor.sv]
// Top level of the ChaCha20 stream XOR block.
//
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid/o_in_ready  | data_byte, start_message, nonce_word0..2
// out     | output    | o_out_valid/i_out_ready| out_byte
// cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A byte inside a block passes the load and XOR states before it reaches the result register,
// and no new item is taken until the block is back in the idle state.
// The first byte of a block also needs a load, 80 steps of the single shared quarter-round
// unit and a finalize step before its output byte is formed.
// Reset is synchronous and clears position, counter, nonce and key.
// A result waiting on the output holds the next item only at its last step.
`timescale 1ns / 1ps
module chacha20_stream_xor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [cc20_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_message,
    input  logic [31:0] i_nonce_word0,
    input  logic [31:0] i_nonce_word1,
    input  logic [31:0] i_nonce_word2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte
);
    import cc20_pkg::*;

    t_cmd    cmd;
    t_status status;

    cc20_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_start_message (i_start_message),
        .i_out_ready     (i_out_ready),
        .i_status        (status),
        .o_in_ready      (o_in_ready),
        .o_out_valid     (o_out_valid),
        .o_cmd           (cmd)
    );

    cc20_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_byte     (i_data_byte),
        .i_nonce_word0   (i_nonce_word0),
        .i_nonce_word1   (i_nonce_word1),
        .i_nonce_word2   (i_nonce_word2),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_byte      (o_out_byte)
    );

endmodule

[design/cc20_datapath.sv]
// Datapath: cipher state, shared quarter-round unit and byte XOR.
`timescale 1ns / 1ps
module cc20_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cc20_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cc20_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [7:0]                   i_data_byte,
    input  logic [31:0]                  i_nonce_word0,
    input  logic [31:0]                  i_nonce_word1,
    input  logic [31:0]                  i_nonce_word2,
    input  cc20_pkg::t_cmd               i_cmd,
    output cc20_pkg::t_status            o_status,
    output logic [7:0]                   o_out_byte
);
    import cc20_pkg::*;

    logic [63:0] r_key [4];
    logic [31:0] r_counter;
    logic [5:0]  r_pos;
    logic [31:0] r_nonce [3];
    logic [31:0] r_work [16];
    logic [31:0] r_ks [16];
    logic [7:0]  r_data;
    logic [7:0]  r_out;

    logic [31:0] init_w [16];
    logic [3:0]  ia, ib, ic, id;
    logic [31:0] a0, b0, c0, d0, a1, b1, c1, d1, a2, b2, c2, d2;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    always_comb begin
        init_w[0] = SIGMA0;
        init_w[1] = SIGMA1;
        init_w[2] = SIGMA2;
        init_w[3] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            init_w[4 + 2 * i] = r_key[i][31:0];
            init_w[5 + 2 * i] = r_key[i][63:32];
        end
        init_w[12] = r_counter;
        init_w[13] = r_nonce[0];
        init_w[14] = r_nonce[1];
        init_w[15] = r_nonce[2];
    end

    // Column quarter rounds first, then the diagonal ones.
    always_comb begin
        case (i_cmd.qr_sel)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        a0 = r_work[ia];
        b0 = r_work[ib];
        c0 = r_work[ic];
        d0 = r_work[id];
        a1 = a0 + b0;
        d1 = rotl(d0 ^ a1, 16);
        c1 = c0 + d1;
        b1 = rotl(b0 ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, 7);
    end

    assign ks_word  = r_ks[r_pos[5:2]];
    assign ks_byte  = 8'(ks_word >> {r_pos[1:0], 3'b000});
    assign o_status.need_block = (r_pos == 6'd0);
    assign o_out_byte = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            for (int i = 0; i < 3; i++) r_nonce[i] <= '0;
            r_counter <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY0: r_key[0] <= i_cfg_data;
                    REG_KEY1: r_key[1] <= i_cfg_data;
                    REG_KEY2: r_key[2] <= i_cfg_data;
                    REG_KEY3: r_key[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.take_item && i_cmd.restart) begin
                r_nonce[0] <= i_nonce_word0;
                r_nonce[1] <= i_nonce_word1;
                r_nonce[2] <= i_nonce_word2;
                r_counter  <= '0;
                r_pos      <= '0;
            end
            if (i_cmd.make_out) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd63) r_counter <= r_counter + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) r_data <= i_data_byte;
        if (i_cmd.load) begin
            for (int i = 0; i < 16; i++) r_work[i] <= init_w[i];
        end else if (i_cmd.qr_step) begin
            r_work[ia] <= a2;
            r_work[ib] <= b2;
            r_work[ic] <= c2;
            r_work[id] <= d2;
        end
        if (i_cmd.finalize) begin
            for (int i = 0; i < 16; i++) r_ks[i] <= r_work[i] + init_w[i];
        end
        if (i_cmd.make_out) r_out <= r_data ^ ks_byte;
    end

endmodule

[design/cc20_ctrl.sv]
// Controller: sequences item intake, block generation and output transfer.
`timescale 1ns / 1ps
module cc20_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_start_message,
    input  logic               i_out_ready,
    input  cc20_pkg::t_status  i_status,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output cc20_pkg::t_cmd     o_cmd
);
    import cc20_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_qr, n_qr;
    logic [3:0] r_dr, n_dr;
    logic       r_need, n_need;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qr        <= '0;
            r_dr        <= '0;
            r_need      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qr        <= n_qr;
            r_dr        <= n_dr;
            r_need      <= n_need;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_qr        = r_qr;
        n_dr        = r_dr;
        n_need      = r_need;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.qr_sel = r_qr;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                // A finished byte may still wait in the output register.
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    o_cmd.restart   = i_start_message;
                    n_need  = i_start_message || i_status.need_block;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_need) begin
                    o_cmd.load = 1'b1;
                    n_qr    = '0;
                    n_dr    = '0;
                    n_state = S_ROUND;
                end else begin
                    n_state = S_XOR;
                end
            end
            S_ROUND: begin
                o_cmd.qr_step = 1'b1;
                n_qr = r_qr + 3'd1;
                if (r_qr == 3'(QR_PER_DOUBLE - 1)) begin
                    n_dr = r_dr + 4'd1;
                    if (r_dr == 4'(DOUBLE_ROUNDS - 1)) n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.finalize = 1'b1;
                n_state = S_XOR;
            end
            S_XOR: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.make_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[design/cc20_checker.sv]
// Port-level checker for the ChaCha20 stream XOR block, bound to the top level.
`timescale 1ns / 1ps
module cc20_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte
);

    // A held result keeps its value until the transfer.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte))
        else $error("output byte changed while stalled");

    // An accepted item blocks further intake for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // With the output empty, an accepted item shows no result in the next cycle.
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    // Nothing is offered during reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind chacha20_stream_xor cc20_checker u_cc20_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte)
);
